FILE: src/lmac_pkg.sv
// ---------------------------------------------------------------------------
// lmac_pkg
// Shared types and constants for the label mask area/centroid statistics unit.
// ---------------------------------------------------------------------------
package lmac_pkg;

  localparam int LABEL_W     = 8;
  localparam int DIM_W       = 13;
  localparam int AREA_W      = 25;
  localparam int SUM_W       = 36;
  localparam int DEN_W       = AREA_W + DIM_W;
  localparam int CENT_W      = 16;
  localparam int PRESENT_W   = 255;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 320;

  localparam logic [LABEL_W-1:0] EXCLUDED_LABEL = 8'd255;

  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
  localparam logic [LABEL_W-1:0] TARGET_RESET = 8'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LABEL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic prep;
    logic step;
    logic load_pix;
    logic load_frame;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

FILE: src/lmac_ctrl.sv
// ---------------------------------------------------------------------------
// lmac_ctrl
// Sequencer: pixel acceptance, end-of-frame divide steps, output word valid.
// ---------------------------------------------------------------------------
module lmac_ctrl #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  lmac_pkg::sts_t     sts,
  output lmac_pkg::cmd_t     cmd
);

  localparam int CNT_W = $clog2(FRACTION_BITS);

  lmac_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmac_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    out_free  = !out_valid_r || out_tready;
    in_tready = (state_r == lmac_pkg::ST_IDLE) && out_free;
    case (state_r)
      lmac_pkg::ST_IDLE: begin
        if (in_tvalid && out_free) begin
          cmd.accept = 1'b1;
          if (sts.last) begin
            state_nxt = lmac_pkg::ST_MUL;
          end else begin
            cmd.load_pix = 1'b1;
          end
        end
      end
      lmac_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = lmac_pkg::ST_PREP;
      end
      lmac_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = lmac_pkg::ST_DIV;
      end
      lmac_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == CNT_W'(FRACTION_BITS - 1)) begin
          state_nxt = lmac_pkg::ST_DONE;
        end else begin
          cnt_nxt = CNT_W'(cnt_r + 1'b1);
        end
      end
      lmac_pkg::ST_DONE: begin
        // hold the frame word until the output register frees up
        if (out_free) begin
          cmd.load_frame = 1'b1;
          state_nxt      = lmac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lmac_pkg::ST_IDLE;
      end
    endcase
    if (cmd.load_pix || cmd.load_frame) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_last_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.last) |=> (state_r == lmac_pkg::ST_MUL))
    else $error("last pixel did not start the centroid divide");

  a_frame_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_frame |-> (!out_valid_r || out_tready))
    else $error("frame word loaded over an untaken word");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmac_pkg::ST_PREP) |-> ##(FRACTION_BITS + 1)
    (state_r == lmac_pkg::ST_DONE))
    else $error("divide did not run the expected number of steps");
`endif

endmodule

FILE: src/lmac_div.sv
// ---------------------------------------------------------------------------
// lmac_div
// One centroid lane: registered area*dim product, then a restoring divider
// that produces one fraction bit per step, saturating when sum >= area*dim.
// ---------------------------------------------------------------------------
module lmac_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  lmac_pkg::cmd_t                cmd,
  input  logic [lmac_pkg::AREA_W-1:0]   area,
  input  logic [lmac_pkg::DIM_W-1:0]    dim,
  input  logic [lmac_pkg::SUM_W-1:0]    sum,
  output logic [lmac_pkg::CENT_W-1:0]   quot
);

  localparam int DEN_W = lmac_pkg::DEN_W;

  logic [DEN_W-1:0]         den_r;
  logic [DEN_W-1:0]         rem_r;
  logic [FRACTION_BITS-1:0] q_r;
  logic                     sat_r;
  logic [DEN_W:0]           rem_dbl;
  logic [DEN_W:0]           rem_sub;
  logic                     fits;

  always_comb begin
    rem_dbl = {rem_r, 1'b0};
    rem_sub = rem_dbl - {1'b0, den_r};
    fits    = rem_dbl >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      den_r <= DEN_W'(area) * DEN_W'(dim);
    end
    if (cmd.prep) begin
      rem_r <= DEN_W'(sum);
      sat_r <= DEN_W'(sum) >= den_r;
      q_r   <= '0;
    end else if (cmd.step) begin
      rem_r <= fits ? rem_sub[DEN_W-1:0] : rem_dbl[DEN_W-1:0];
      q_r   <= {q_r[FRACTION_BITS-2:0], fits};
    end
  end

  // a quotient of one or more clips to the largest fraction
  assign quot = sat_r ? lmac_pkg::CENT_W'({FRACTION_BITS{1'b1}})
                      : lmac_pkg::CENT_W'(q_r);

endmodule

FILE: src/lmac_dpath.sv
// ---------------------------------------------------------------------------
// lmac_dpath
// Datapath: configuration registers, raster counters, accumulators,
// presence map, two centroid lanes and the output word register.
// ---------------------------------------------------------------------------
module lmac_dpath #(
  parameter int MAX_DIM       = 4096,
  parameter int LABEL_COUNT   = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [lmac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lmac_pkg::DIM_W-1:0]         cfg_data,
  input  logic [lmac_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  lmac_pkg::cmd_t                     cmd,
  output lmac_pkg::sts_t                     sts,
  output logic [lmac_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast
);

  localparam int DIM_W   = lmac_pkg::DIM_W;
  localparam int AREA_W  = lmac_pkg::AREA_W;
  localparam int SUM_W   = lmac_pkg::SUM_W;
  localparam int CENT_W  = lmac_pkg::CENT_W;
  localparam int LABEL_W = lmac_pkg::LABEL_W;
  localparam int PRES_W  = lmac_pkg::PRESENT_W;
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int CMP_W   = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
  localparam int PAD_W   = lmac_pkg::OUT_TDATA_W - (2 + AREA_W + 2 * CENT_W + PRES_W);

  logic [DIM_W-1:0]       width_r, height_r;
  logic [LABEL_W-1:0]     target_r;
  logic [CNT_W-1:0]       col_r, col_nxt;
  logic [CNT_W-1:0]       row_r, row_nxt;
  logic [AREA_W-1:0]      area_r, area_nxt, area_base;
  logic [SUM_W-1:0]       col_sum_r, col_sum_nxt, col_sum_base;
  logic [SUM_W-1:0]       row_sum_r, row_sum_nxt, row_sum_base;
  logic [LABEL_COUNT-1:0] seen_r, seen_nxt, mark;
  logic                   hit_r;

  logic [DIM_W-1:0]       w_eff, h_eff;
  logic [CMP_W-1:0]       col_inc, row_inc;
  logic [LABEL_W-1:0]     label;
  logic                   hit, row_end, last, first, found;
  logic [AREA_W:0]        area_add;
  logic [SUM_W:0]         col_add, row_add;
  logic [CENT_W-1:0]      quot_x, quot_y;
  logic [PRES_W-1:0]      present;

  logic                   o_hit_r, o_last_r, o_found_r;
  logic [AREA_W-1:0]      o_area_r;
  logic [CENT_W-1:0]      o_cx_r, o_cy_r;
  logic [PRES_W-1:0]      o_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lmac_pkg::WIDTH_RESET;
      height_r <= lmac_pkg::HEIGHT_RESET;
      target_r <= lmac_pkg::TARGET_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lmac_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_data;
        lmac_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_data;
        lmac_pkg::CFG_TARGET_LABEL: target_r <= cfg_data[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(width_r) > MAX_DIM) begin
      w_eff = DIM_W'(MAX_DIM);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(height_r) > MAX_DIM) begin
      h_eff = DIM_W'(MAX_DIM);
    end else begin
      h_eff = height_r;
    end
  end

  always_comb begin
    label    = in_tdata[LABEL_W-1:0];
    hit      = (label == target_r);
    col_inc  = CMP_W'(col_r) + CMP_W'(1);
    row_inc  = CMP_W'(row_r) + CMP_W'(1);
    // a counter past a shrunken size counts as sitting on the last column/row
    row_end  = col_inc >= CMP_W'(w_eff);
    last     = row_end && (row_inc >= CMP_W'(h_eff));
    first    = (col_r == '0) && (row_r == '0);
    sts.last = last;

    area_base    = first ? '0 : area_r;
    col_sum_base = first ? '0 : col_sum_r;
    row_sum_base = first ? '0 : row_sum_r;

    area_add = (AREA_W + 1)'(area_base) + (AREA_W + 1)'(1);
    col_add  = (SUM_W + 1)'(col_sum_base) + (SUM_W + 1)'(col_r);
    row_add  = (SUM_W + 1)'(row_sum_base) + (SUM_W + 1)'(row_r);

    if (hit) begin
      area_nxt    = area_add[AREA_W] ? '1 : area_add[AREA_W-1:0];
      col_sum_nxt = col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
      row_sum_nxt = row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
    end else begin
      area_nxt    = area_base;
      col_sum_nxt = col_sum_base;
      row_sum_nxt = row_sum_base;
    end

    for (int i = 0; i < LABEL_COUNT; i++) begin
      mark[i] = (label == LABEL_W'(i)) && (label != lmac_pkg::EXCLUDED_LABEL);
    end
    seen_nxt = (first ? '0 : seen_r) | mark;

    if (row_end) begin
      col_nxt = '0;
      row_nxt = last ? '0 : CNT_W'(row_inc);
    end else begin
      col_nxt = CNT_W'(col_inc);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      area_r    <= area_nxt;
      col_sum_r <= col_sum_nxt;
      row_sum_r <= row_sum_nxt;
      seen_r    <= seen_nxt;
      hit_r     <= hit;
    end
  end

  lmac_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div_x (
    .clk  (clk),
    .cmd  (cmd),
    .area (area_r),
    .dim  (w_eff),
    .sum  (col_sum_r),
    .quot (quot_x)
  );

  lmac_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div_y (
    .clk  (clk),
    .cmd  (cmd),
    .area (area_r),
    .dim  (h_eff),
    .sum  (row_sum_r),
    .quot (quot_y)
  );

  for (genvar g = 0; g < PRES_W; g++) begin : g_present
    if (g < LABEL_COUNT) begin : g_seen
      assign present[g] = seen_r[g];
    end else begin : g_none
      assign present[g] = 1'b0;
    end
  end

  assign found = (area_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      o_hit_r     <= hit;
      o_last_r    <= 1'b0;
      o_found_r   <= 1'b0;
      o_area_r    <= '0;
      o_cx_r      <= '0;
      o_cy_r      <= '0;
      o_present_r <= '0;
    end else if (cmd.load_frame) begin
      o_hit_r     <= hit_r;
      o_last_r    <= 1'b1;
      o_found_r   <= found;
      o_area_r    <= area_r;
      o_cx_r      <= found ? quot_x : '0;
      o_cy_r      <= found ? quot_y : '0;
      o_present_r <= present;
    end
  end

  assign out_tdata = {{PAD_W{1'b0}}, o_present_r, o_cy_r, o_cx_r, o_area_r,
                      o_found_r, o_hit_r};
  assign out_tlast = o_last_r;

endmodule

FILE: src/label_mask_area_centroid_stats_unit.sv
// ---------------------------------------------------------------------------
// label_mask_area_centroid_stats_unit
// Per-pixel target mask plus per-frame area, centroid and label presence.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one 8-bit class label per word, raster order, frame size from the
//           frame_width/frame_height registers.
//   out_* : one word per pixel: mask bit; on the frame's last pixel tlast is
//           set and the word carries area, found flag, Q0.16 centroid and the
//           255-bit presence map (all zero on other pixels).
//   cfg_* : register writes (0 width, 1 height, 2 target label), always ready;
//           write only while the unit is idle.
// Throughput: one pixel per cycle inside a frame, unless the output register
//   holds an untaken word. The last pixel of a frame is followed by a
//   multiply step, a setup step, one step per fraction bit in the restoring
//   divider and the load of the frame word; no pixel is taken meanwhile.
// Latency: a pixel's word is valid the cycle after its acceptance; the frame
//   word is loaded once the divide ends and the output register is free.
// Reset: registers return to 640 x 480, target 0, counters to the frame start.
// Stall: the output register holds a word until taken; a new pixel is taken
//   in the same cycle the held word leaves.
// ---------------------------------------------------------------------------
module label_mask_area_centroid_stats_unit #(
  parameter int MAX_DIM       = 4096,
  parameter int LABEL_COUNT   = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lmac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lmac_pkg::DIM_W-1:0]         cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] pixel_label
  input  logic [lmac_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] in_class, [1] class_found, [26:2] class_area, [42:27] centroid_x,
  // [58:43] centroid_y, [122:59] present_word0, [186:123] present_word1,
  // [250:187] present_word2, [313:251] present_word3, [319:314] zero
  output logic [lmac_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // frame_done
  output logic                               out_tlast
);

  lmac_pkg::cmd_t cmd;
  lmac_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  lmac_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lmac_dpath #(
    .MAX_DIM       (MAX_DIM),
    .LABEL_COUNT   (LABEL_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

FILE: test/label_mask_area_centroid_stats_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// label_mask_area_centroid_stats_unit_tb
// Self-checking bench for the label mask area/centroid statistics unit.
// A short stimulus table (register extremes, excluded label, empty class,
// centroid saturation, size change inside a frame) runs first. A wide and a
// tall frame cut short by size changes follow, then random small frames.
// Every output word is compared field by field against a cycle-free model
// kept in the bench. Traffic is bursty on the input and stalled on the output.
// ---------------------------------------------------------------------------
module label_mask_area_centroid_stats_unit_tb;

  localparam int LABEL_W     = lmac_pkg::LABEL_W;
  localparam int DIM_W       = lmac_pkg::DIM_W;
  localparam int AREA_W      = lmac_pkg::AREA_W;
  localparam int SUM_W       = lmac_pkg::SUM_W;
  localparam int CENT_W      = lmac_pkg::CENT_W;
  localparam int CFG_IDX_W   = lmac_pkg::CFG_IDX_W;
  localparam int IN_TDATA_W  = lmac_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = lmac_pkg::OUT_TDATA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = lmac_pkg::CFG_FRAME_WIDTH;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = lmac_pkg::CFG_FRAME_HEIGHT;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LABEL = lmac_pkg::CFG_TARGET_LABEL;

  localparam int DIM_LIMIT      = 4096;
  localparam int FRAC_BITS      = 16;
  localparam int RANDOM_PIXELS  = 320;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [SUM_W-1:0]     SUM_TOP    = '1;

  typedef struct packed {
    logic                in_class;
    logic                frame_done;
    logic                class_found;
    logic [AREA_W-1:0]   class_area;
    logic [CENT_W-1:0]   centroid_x;
    logic [CENT_W-1:0]   centroid_y;
    logic [63:0]         present0;
    logic [63:0]         present1;
    logic [63:0]         present2;
    logic [62:0]         present3;
  } mask_stats_t;

  typedef enum logic { ROW_REG, ROW_PIXEL } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [DIM_W-1:0]      value;
    logic                  typed;
    mask_stats_t           word;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [DIM_W-1:0]        cfg_data = '0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;

  // bench copy of the unit's registers and frame state
  logic [DIM_W-1:0]        reg_width  = lmac_pkg::WIDTH_RESET;
  logic [DIM_W-1:0]        reg_height = lmac_pkg::HEIGHT_RESET;
  logic [LABEL_W-1:0]      reg_target = lmac_pkg::TARGET_RESET;
  logic [11:0]             col_cnt = '0;
  logic [11:0]             row_cnt = '0;
  logic [AREA_W-1:0]       area_acc = '0;
  logic [SUM_W-1:0]        col_acc = '0;
  logic [SUM_W-1:0]        row_acc = '0;
  logic [255:0]            seen = '0;

  mask_stats_t             stats_due[$];
  plan_row_t               plan[$];
  int                      mismatches = 0;
  int                      burst_left = 0;
  int                      stuck_cycles = 0;
  bit                      hold_request = 1'b0;

  always #10 clk = ~clk;

  label_mask_area_centroid_stats_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return DIM_W'(1);
    if (v > DIM_LIMIT) return DIM_W'(DIM_LIMIT);
    return v;
  endfunction

  function automatic logic [CENT_W-1:0] fraction(input logic [SUM_W-1:0] sum,
                                                 input logic [AREA_W-1:0] area,
                                                 input logic [DIM_W-1:0] dim);
    longint unsigned den;
    longint unsigned q;
    den = area;
    den = den * dim;
    if (den == 0) return '0;
    q = sum;
    q = (q << FRAC_BITS) / den;
    if (q > (64'd1 << FRAC_BITS) - 1) q = (64'd1 << FRAC_BITS) - 1;
    return q[CENT_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                               input logic [11:0] step);
    longint unsigned s;
    s = acc;
    s = s + step;
    return (s > SUM_TOP) ? SUM_TOP : s[SUM_W-1:0];
  endfunction

  // Advance the frame state by one pixel and return the word it produces.
  function automatic mask_stats_t predict_pixel(input logic [LABEL_W-1:0] label);
    mask_stats_t      w;
    logic [DIM_W-1:0] wd;
    logic [DIM_W-1:0] ht;
    logic             hit;
    logic             row_end;
    logic             last;
    wd = eff_dim(reg_width);
    ht = eff_dim(reg_height);
    hit = (label == reg_target);
    // a counter past a shrunken size counts as sitting on the last column/row
    row_end = (col_cnt + 1 >= wd);
    last = row_end && (row_cnt + 1 >= ht);
    if (col_cnt == 0 && row_cnt == 0) begin
      area_acc = '0;
      col_acc = '0;
      row_acc = '0;
      seen = '0;
    end
    if (hit) begin
      if (area_acc != '1) area_acc = area_acc + 1'b1;
      col_acc = sat_sum(col_acc, col_cnt);
      row_acc = sat_sum(row_acc, row_cnt);
    end
    if (label != lmac_pkg::EXCLUDED_LABEL) seen[label] = 1'b1;
    w = '0;
    w.in_class = hit;
    if (last) begin
      w.frame_done = 1'b1;
      w.class_area = area_acc;
      if (area_acc != 0) begin
        w.class_found = 1'b1;
        w.centroid_x = fraction(col_acc, area_acc, wd);
        w.centroid_y = fraction(row_acc, area_acc, ht);
      end
      w.present0 = seen[63:0];
      w.present1 = seen[127:64];
      w.present2 = seen[191:128];
      w.present3 = seen[254:192];
    end
    if (row_end) begin
      col_cnt = '0;
      row_cnt = last ? 12'd0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return w;
  endfunction

  function automatic mask_stats_t open_word(input logic ic);
    mask_stats_t w;
    w = '0;
    w.in_class = ic;
    return w;
  endfunction

  function automatic mask_stats_t done_word(input logic ic, input logic found,
                                            input logic [AREA_W-1:0] area,
                                            input logic [63:0] p0, input logic [63:0] p1,
                                            input logic [63:0] p2, input logic [62:0] p3);
    mask_stats_t w;
    w = '0;
    w.in_class = ic;
    w.frame_done = 1'b1;
    w.class_found = found;
    w.class_area = area;
    w.present0 = p0;
    w.present1 = p1;
    w.present2 = p2;
    w.present3 = p3;
    return w;
  endfunction

  function automatic plan_row_t make_row(input row_kind_t kind,
                                         input logic [CFG_IDX_W-1:0] idx,
                                         input logic [DIM_W-1:0] value,
                                         input logic typed, input mask_stats_t word);
    plan_row_t r;
    r.kind = kind;
    r.idx = idx;
    r.value = value;
    r.typed = typed;
    r.word = word;
    return r;
  endfunction

  // Append one row at the end of the stimulus table.
  function automatic void queue_row(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return reg_target;
    if (r == 4) return lmac_pkg::EXCLUDED_LABEL;
    return LABEL_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    if ($urandom_range(0, 9) == 0) return '0;
    return DIM_W'($urandom_range(1, 6));
  endfunction

  // Drop valid and hold until every expected word has been taken.
  task automatic wait_results_idle();
    if (in_tvalid) in_tvalid <= 1'b0;
    @(posedge clk);
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    wait_results_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_WIDTH:  reg_width  = value;
      CFG_FRAME_HEIGHT: reg_height = value;
      CFG_TARGET_LABEL: reg_target = value[LABEL_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one label; valid stays up inside a burst, drops for a gap after it.
  task automatic send_pixel(input logic [LABEL_W-1:0] label, input logic typed,
                            input mask_stats_t typed_word);
    mask_stats_t w;
    int          gap;
    in_tvalid <= 1'b1;
    in_tdata  <= label;
    do @(posedge clk); while (!in_tready);
    w = predict_pixel(label);
    stats_due.insert(stats_due.size(), typed ? typed_word : w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(0, 40);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic cmp_field(input string name, input logic [63:0] exp_v, input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    mask_stats_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (stats_due.size() == 0) begin
        $error("output word with nothing expected");
        mismatches++;
      end else begin
        e = stats_due.pop_front();
        // out_tdata: in_class, class_found, area, cx, cy, presence words 0..3
        cmp_field("in_class", e.in_class, out_tdata[0]);
        cmp_field("frame_done", e.frame_done, out_tlast);
        cmp_field("class_found", e.class_found, out_tdata[1]);
        cmp_field("class_area", e.class_area, out_tdata[26:2]);
        cmp_field("centroid_x", e.centroid_x, out_tdata[42:27]);
        cmp_field("centroid_y", e.centroid_y, out_tdata[58:43]);
        cmp_field("present_word0", e.present0, out_tdata[122:59]);
        cmp_field("present_word1", e.present1, out_tdata[186:123]);
        cmp_field("present_word2", e.present2, out_tdata[250:187]);
        cmp_field("present_word3", e.present3, out_tdata[313:251]);
      end
    end
  end

  initial begin : receiver
    int hold_left;
    int cyc;
    hold_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case ((cyc / 97) % 4)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 1);
          2:       out_tready <= (cyc % 3 == 0);
          default: out_tready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    int          sent;
    int          n;
    int          frame_px;
    bit          held;
    plan_row_t   r;

    sent = 0;
    held = 1'b0;

    // after reset: 640 x 480, target 0
    queue_row(make_row(ROW_PIXEL, '0, 13'd0, 1'b1, open_word(1'b1)));
    queue_row(make_row(ROW_PIXEL, '0, 13'd255, 1'b1, open_word(1'b0)));
    // shrink to 1 x 1 inside the open frame: the next pixel closes it
    queue_row(make_row(ROW_REG, CFG_FRAME_WIDTH, 13'd1, 1'b0, '0));
    queue_row(make_row(ROW_REG, CFG_FRAME_HEIGHT, 13'd1, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd7, 1'b0, '0));
    // excluded label as target, empty class, top presence bit
    queue_row(make_row(ROW_REG, CFG_TARGET_LABEL, 13'h0FF, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd255, 1'b1,
                       done_word(1'b1, 1'b1, 25'd1, '0, '0, '0, '0)));
    queue_row(make_row(ROW_PIXEL, '0, 13'd0, 1'b1,
                       done_word(1'b0, 1'b0, 25'd0, 64'h1, '0, '0, '0)));
    queue_row(make_row(ROW_PIXEL, '0, 13'd254, 1'b1,
                       done_word(1'b0, 1'b0, 25'd0, '0, '0, '0, 63'h1 << 62)));
    // zero sizes act as 1; target write with upper data bits set
    queue_row(make_row(ROW_REG, CFG_FRAME_WIDTH, 13'd0, 1'b0, '0));
    queue_row(make_row(ROW_REG, CFG_FRAME_HEIGHT, 13'd0, 1'b0, '0));
    queue_row(make_row(ROW_REG, CFG_TARGET_LABEL, 13'h1F80, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd128, 1'b1,
                       done_word(1'b1, 1'b1, 25'd1, '0, '0, 64'h1, '0)));
    queue_row(make_row(ROW_PIXEL, '0, 13'd63, 1'b1,
                       done_word(1'b0, 1'b0, 25'd0, 64'h8000_0000_0000_0000, '0, '0, '0)));
    queue_row(make_row(ROW_PIXEL, '0, 13'd64, 1'b1,
                       done_word(1'b0, 1'b0, 25'd0, '0, 64'h1, '0, '0)));
    queue_row(make_row(ROW_REG, CFG_UNUSED, 13'h1FFF, 1'b0, '0));
    // 3 x 2 frame with a real centroid
    queue_row(make_row(ROW_REG, CFG_FRAME_WIDTH, 13'd3, 1'b0, '0));
    queue_row(make_row(ROW_REG, CFG_FRAME_HEIGHT, 13'd2, 1'b0, '0));
    queue_row(make_row(ROW_REG, CFG_TARGET_LABEL, 13'd5, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd5, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd5, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd0, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd1, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd5, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd255, 1'b0, '0));
    // narrow the frame under a partial row: column sum outgrows area * width
    queue_row(make_row(ROW_PIXEL, '0, 13'd9, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd5, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd5, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd9, 1'b0, '0));
    queue_row(make_row(ROW_REG, CFG_FRAME_WIDTH, 13'd1, 1'b0, '0));
    queue_row(make_row(ROW_PIXEL, '0, 13'd5, 1'b0, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_REG) write_reg(r.idx, r.value);
      else send_pixel(r.value[LABEL_W-1:0], r.typed, r.word);
    end

    // widest row, then tallest column, each cut short by a size change
    write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    write_reg(CFG_TARGET_LABEL, DIM_W'($urandom_range(0, 255)));
    repeat (20) send_pixel(pick_label(), 1'b0, '0);
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd4096);
    repeat (20) send_pixel(pick_label(), 1'b0, '0);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);

    while (sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 3) != 0) write_reg(CFG_FRAME_WIDTH, pick_dim());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_FRAME_HEIGHT, pick_dim());
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CFG_TARGET_LABEL, DIM_W'($urandom_range(0, 8191)));
      end
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, DIM_W'($urandom_range(0, 8191)));
      frame_px = eff_dim(reg_width) * eff_dim(reg_height);
      n = frame_px * $urandom_range(1, 3);
      // partial frame: the next register write lands inside it
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, frame_px);
      if (!held && sent >= 150) begin
        held = 1'b1;
        hold_request = 1'b1;
        n = n + 60;
      end
      repeat (n) begin
        send_pixel(pick_label(), 1'b0, '0);
        sent++;
      end
    end

    wait_results_idle();
    repeat (40) @(posedge clk);
    if (stats_due.size() != 0) begin
      $error("%0d expected words never arrived", stats_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
